// ===== rtl/sorted_word_table_lookup_top_defines.svh =====
// Assertion macros used by the port-level checker of the sorted word table lookup block.
`ifndef SORTED_WORD_TABLE_LOOKUP_TOP_DEFINES_SVH
`define SORTED_WORD_TABLE_LOOKUP_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define SWTL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swtl check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define SWTL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swtl check failed");

`endif

// ===== rtl/swtl_pkg.sv =====
// Package with the sizes, codes and types of the sorted word table lookup block.
package swtl_pkg;

	// Table geometry.
	localparam int TABLE_DEPTH = 1024;
	localparam int MAX_CHARS   = 8;
	localparam int ADDR_W      = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths.
	localparam int WORD_W   = 64;
	localparam int CHARS_W  = 4;
	localparam int ACTION_W = 2;
	localparam int STATUS_W = 2;
	localparam int POS_W    = 10;

	// Bytes beyond the last usable character are forced to zero.
	localparam logic [WORD_W-1:0] KEY_MASK = {WORD_W{1'b1}} << (WORD_W - 8 * MAX_CHARS);

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [CHARS_W-1:0] WLEN_RESET = 4'd5;
	localparam logic REG_WORD_LENGTH = 1'b0;

	// Item actions.
	typedef enum logic [ACTION_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_APPEND = 2'd1,
		ACT_LOOKUP = 2'd2
	} action_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_DONE   = 2'd0,
		STAT_FULL   = 2'd1,
		STAT_SKIP   = 2'd2,
		STAT_LOOKUP = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SEARCH,
		ST_FINAL,
		ST_FINISH
	} state_t;

endpackage

// ===== rtl/swtl_if.sv =====
// Valid/ready channel interfaces for the input items and the result items.
interface swtl_in_if import swtl_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHARS_W-1:0]  word_chars;
	logic [WORD_W-1:0]   word_bits;

	modport source (output valid, action, word_chars, word_bits, input ready);
	modport sink (input valid, action, word_chars, word_bits, output ready);
endinterface

interface swtl_out_if import swtl_pkg::*;;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic                found;
	logic [POS_W-1:0]    position;

	modport source (output valid, status, found, position, input ready);
	modport sink (input valid, status, found, position, output ready);
endinterface

// ===== rtl/swtl_ram.sv =====
// Generic single-port synchronous RAM with a registered read.
module swtl_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     en,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// One access per cycle: a write, or a read whose data appears next cycle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata <= mem_q[addr];
			end
		end
	end

endmodule

// ===== rtl/sorted_word_table_lookup_top.sv =====
// Top level of the sorted word table lookup block.
//
// Items arrive on the req channel (action, word_chars, word_bits) and one result per
// item leaves on the rsp channel (status, found, position); both use valid/ready and a
// transfer happens on a rising edge with both high. The word_length register is written
// through the APB port at byte address 0; pready is always high.
// The block works on one item at a time. An item other than a lookup passes through the
// execute and finish states before req.ready returns. A lookup runs a binary search over
// the stored entries, one read of the single-port table memory per halving step, followed
// by a read of the entry at the lower bound for the final compare with the key; that read
// is skipped when the key lies above every entry.
// A finished result moves into the output register, so the next item is taken while the
// previous result still waits. If the receiver stalls, the result holds in the output
// register and the next finished item waits in the controller until the register frees.
// Reset empties the table (entry count zero), sets word_length to 5 and drops rsp.valid;
// the table memory itself is not cleared, and no clearing pass is needed.
module sorted_word_table_lookup_top import swtl_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	swtl_in_if.sink               req,
	swtl_out_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	state_t state_q, state_d;

	logic [ACTION_W-1:0] action_q;
	logic [CHARS_W-1:0]  chars_q;
	logic [WORD_W-1:0]   key_q;
	logic [CHARS_W-1:0]  wlen_q;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    lo_q, hi_q, mid_q;

	logic [STATUS_W-1:0] res_status_q, res_status_d;
	logic                res_found_q, res_found_d;
	logic [POS_W-1:0]    res_pos_q, res_pos_d;
	logic                res_load;

	logic                out_valid_q;
	logic [STATUS_W-1:0] out_status_q;
	logic                out_found_q;
	logic [POS_W-1:0]    out_pos_q;
	logic                out_free;

	logic              ram_en, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic [CNT_W-1:0] srch_lo, srch_hi, srch_mid;
	logic             srch_more, srch_tail, rd_less;
	logic             cfg_write;

	// Table memory.
	swtl_ram #(
		.WIDTH (WORD_W),
		.DEPTH (TABLE_DEPTH)
	) u_table (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	// Configuration port: the register index is taken from the word address.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_WORD_LENGTH) begin
			prdata = APB_DATA_W'(wlen_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wlen_q <= WLEN_RESET;
		end else if (cfg_write && paddr[2] == REG_WORD_LENGTH) begin
			wlen_q <= pwdata[CHARS_W-1:0];
		end
	end

	// Narrow bounds by the entry read (else take all entries), then pick the next probe.
	assign rd_less = ram_rdata < key_q;

	always_comb begin
		if (state_q == ST_SEARCH) begin
			srch_lo = rd_less ? mid_q + CNT_W'(1) : lo_q;
			srch_hi = rd_less ? hi_q : mid_q;
		end else begin
			srch_lo = '0;
			srch_hi = count_q;
		end
		srch_mid  = srch_lo + ((srch_hi - srch_lo) >> 1);
		srch_more = srch_lo < srch_hi;
		srch_tail = srch_lo < count_q;
	end

	assign out_free = !out_valid_q || rsp.ready;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req.valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (action_q == ACT_LOOKUP) begin
					if (srch_more) state_d = ST_SEARCH;
					else if (srch_tail) state_d = ST_FINAL;
					else state_d = ST_FINISH;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_SEARCH: begin
				if (srch_more) state_d = ST_SEARCH;
				else if (srch_tail) state_d = ST_FINAL;
				else state_d = ST_FINISH;
			end
			ST_FINAL: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Controller outputs: memory access, entry count and the pending result.
	always_comb begin
		ram_en       = 1'b0;
		ram_we       = 1'b0;
		ram_addr     = srch_mid[ADDR_W-1:0];
		ram_wdata    = key_q;
		count_d      = count_q;
		res_load     = 1'b0;
		res_status_d = STAT_DONE;
		res_found_d  = 1'b0;
		res_pos_d    = '0;
		unique case (state_q) inside
			ST_IDLE: begin
			end
			ST_EXEC, ST_SEARCH: begin
				if (state_q == ST_SEARCH || action_q == ACT_LOOKUP) begin
					res_status_d = STAT_LOOKUP;
					if (srch_more) begin
						ram_en = 1'b1;
					end else if (srch_tail) begin
						ram_en   = 1'b1;
						ram_addr = srch_lo[ADDR_W-1:0];
					end else begin
						res_load = 1'b1;
					end
				end else begin
					res_load = 1'b1;
					case (action_q)
						ACT_CLEAR: begin
							count_d = '0;
						end
						ACT_APPEND: begin
							if (chars_q != wlen_q) begin
								res_status_d = STAT_SKIP;
							end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
								res_status_d = STAT_FULL;
							end else begin
								ram_en   = 1'b1;
								ram_we   = 1'b1;
								ram_addr = count_q[ADDR_W-1:0];
								count_d  = count_q + CNT_W'(1);
							end
						end
						default: begin
						end
					endcase
				end
			end
			ST_FINAL: begin
				res_load     = 1'b1;
				res_status_d = STAT_LOOKUP;
				if (ram_rdata == key_q) begin
					res_found_d = 1'b1;
					res_pos_d   = POS_W'(lo_q);
				end
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == ST_IDLE);

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item, search and result payload registers.
	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_q <= req.action;
			chars_q  <= req.word_chars;
			key_q    <= req.word_bits & KEY_MASK;
		end
		if (state_q == ST_EXEC || state_q == ST_SEARCH) begin
			lo_q  <= srch_lo;
			hi_q  <= srch_hi;
			mid_q <= srch_mid;
		end
		if (res_load) begin
			res_status_q <= res_status_d;
			res_found_q  <= res_found_d;
			res_pos_q    <= res_pos_d;
		end
		if (state_q == ST_FINISH && out_free) begin
			out_status_q <= res_status_q;
			out_found_q  <= res_found_q;
			out_pos_q    <= res_pos_q;
		end
	end

	assign rsp.valid    = out_valid_q;
	assign rsp.status   = out_status_q;
	assign rsp.found    = out_found_q;
	assign rsp.position = out_pos_q;

endmodule

// ===== rtl/swtl_chk.sv =====
// Port-level checker for the sorted word table lookup block and its bind statement.
`include "sorted_word_table_lookup_top_defines.svh"

module swtl_chk import swtl_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_ready,
	input logic                rsp_valid,
	input logic                rsp_ready,
	input logic [STATUS_W-1:0] rsp_status,
	input logic                rsp_found,
	input logic [POS_W-1:0]    rsp_position
);

	logic [STATUS_W+POS_W:0] rsp_payload;

	// The whole result payload as one vector.
	assign rsp_payload = {rsp_status, rsp_found, rsp_position};

	// A stalled result stays offered and unchanged.
	`SWTL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

	// Only a lookup can report a hit.
	`SWTL_ASSERT_NOW(a_found_lookup, rsp_valid && rsp_found, rsp_status == STAT_LOOKUP)

	// Clear, append and unused-action results carry no hit and position zero.
	`SWTL_ASSERT_NOW(a_other_zero, rsp_valid && rsp_status != STAT_LOOKUP, !rsp_found && rsp_position == '0)

	// The block works on one item at a time, so req.ready is low in the cycle after a transfer.
	`SWTL_ASSERT_NEXT(a_one_item, req_valid && req_ready, !req_ready)

endmodule

bind sorted_word_table_lookup_top swtl_chk u_swtl_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.rsp_status   (rsp.status),
	.rsp_found    (rsp.found),
	.rsp_position (rsp.position)
);

// ===== verif/swtl_result_check.sv =====
// Checker for the sorted word table lookup block: predicts each result and compares it.
`timescale 1ns / 100ps

module swtl_result_check import swtl_pkg::*; #(
	parameter logic [APB_ADDR_W-1:0] WLEN_ADDR = '0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	swtl_in_if                    req,
	swtl_out_if                   rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic                  pready,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output int                    errors,
	output int                    pending
);

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [POS_W-1:0]    position;
	} outcome_t;

	// Shadow copy of the table, its fill level and the word length register.
	logic [WORD_W-1:0]  shadow_words [TABLE_DEPTH];
	logic [CNT_W-1:0]   shadow_count;
	logic [CHARS_W-1:0] shadow_length;
	outcome_t           awaited [$];
	int                 mismatch_total;

	// Applies one item to the shadow state and returns the result it should give.
	function automatic outcome_t apply_item(input logic [ACTION_W-1:0] act,
			input logic [CHARS_W-1:0] chars, input logic [WORD_W-1:0] bits);
		outcome_t          res;
		logic [WORD_W-1:0] key;
		int                lo;
		int                hi;
		int                mid;
		res.status   = STAT_DONE;
		res.found    = 1'b0;
		res.position = '0;
		key = bits & KEY_MASK;
		case (act)
			ACT_CLEAR: begin
				shadow_count = '0;
			end
			ACT_APPEND: begin
				// The length check wins over the full check.
				if (chars != shadow_length) begin
					res.status = STAT_SKIP;
				end else if (shadow_count >= TABLE_DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					shadow_words[int'(shadow_count)] = key;
					shadow_count = shadow_count + 1'b1;
				end
			end
			ACT_LOOKUP: begin
				// Lower bound: first position whose entry is not below the key.
				lo = 0;
				hi = int'(shadow_count);
				while (lo < hi) begin
					mid = lo + (hi - lo) / 2;
					if (shadow_words[mid] < key) begin
						lo = mid + 1;
					end else begin
						hi = mid;
					end
				end
				res.status = STAT_LOOKUP;
				if (lo < int'(shadow_count)) begin
					if (shadow_words[lo] == key) begin
						res.found    = 1'b1;
						res.position = POS_W'(lo);
					end
				end
			end
			default: begin
			end
		endcase
		return res;
	endfunction

	// Watch register writes, item transfers and result transfers on each edge.
	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			shadow_count   = '0;
			shadow_length  = WLEN_RESET;
			mismatch_total = 0;
			awaited.delete();
			errors  <= 0;
			pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr == WLEN_ADDR) begin
				shadow_length = pwdata[CHARS_W-1:0];
			end
			if (req.valid && req.ready) begin
				awaited.insert(awaited.size(),
					apply_item(req.action, req.word_chars, req.word_bits));
			end
			if (rsp.valid && rsp.ready) begin
				if (awaited.size() == 0) begin
					$error("result transfer with no item outstanding");
					mismatch_total++;
				end else begin
					want = awaited.pop_front();
					if (rsp.status !== want.status) begin
						$error("status: expected %0d, actual %0d", want.status, rsp.status);
						mismatch_total++;
					end
					if (rsp.found !== want.found) begin
						$error("found: expected %0d, actual %0d", want.found, rsp.found);
						mismatch_total++;
					end
					if (rsp.position !== want.position) begin
						$error("position: expected %0d, actual %0d", want.position,
							rsp.position);
						mismatch_total++;
					end
				end
			end
			errors  <= mismatch_total;
			pending <= awaited.size();
		end
	end

endmodule

// ===== verif/sorted_word_table_lookup_top_tb.sv =====
// Testbench top for the sorted word table lookup block: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module sorted_word_table_lookup_top_tb;
	import swtl_pkg::*;

	localparam int                    HALF_PERIOD  = 10;
	localparam int                    CYCLE_LIMIT  = 500000;
	localparam int                    RANDOM_ITEMS = 1350;
	localparam logic [APB_ADDR_W-1:0] WLEN_ADDR    = APB_ADDR_W'(4 * REG_WORD_LENGTH);
	localparam logic [ACTION_W-1:0]   ACT_UNUSED   = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;
	int                    fail_count;
	int                    outstanding;
	int                    cycle_count;
	bit                    gaps_on;
	int                    item_total;
	int                    kind_count [4];
	int                    setting_count;
	int                    fill_count;

	swtl_in_if  req ();
	swtl_out_if rsp ();

	sorted_word_table_lookup_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	swtl_result_check #(.WLEN_ADDR(WLEN_ADDR)) result_check (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rsp     (rsp),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.pready  (pready),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.errors  (fail_count),
		.pending (outstanding)
	);

	// Free-running clock.
	always #(HALF_PERIOD) clk = ~clk;

	// The receiver stalls at random while gaps are enabled.
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= gaps_on ? ($urandom_range(99) >= 30) : 1'b1;
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	// Random packed word of the given length, unused low bytes zero.
	function automatic logic [WORD_W-1:0] make_word(input int len);
		logic [WORD_W-1:0] w;
		if (len > MAX_CHARS) begin
			len = MAX_CHARS;
		end
		w = {$urandom(), $urandom()};
		return w & ({WORD_W{1'b1}} << (WORD_W - 8 * len)) & KEY_MASK;
	endfunction

	// Offers one item, with an optional random gap first, and waits for its transfer.
	task automatic send_item(input logic [ACTION_W-1:0] act, input logic [CHARS_W-1:0] chars,
			input logic [WORD_W-1:0] bits);
		if (gaps_on && $urandom_range(99) < 30) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 18)) @(posedge clk);
		end
		req.valid      <= 1'b1;
		req.action     <= act;
		req.word_chars <= chars;
		req.word_bits  <= bits;
		do @(posedge clk); while (!req.ready);
		item_total++;
		kind_count[act]++;
	endtask

	// Holds the sender back until every outstanding result has come back.
	task automatic settle();
		req.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	// APB write of the word length register: setup cycle, then access cycle.
	task automatic write_length(input int len);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= WLEN_ADDR;
		pwdata  <= APB_DATA_W'(len);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		setting_count++;
	endtask

	// Any word length other than the configured one.
	function automatic logic [CHARS_W-1:0] other_length(input int len);
		logic [CHARS_W-1:0] c;
		do c = CHARS_W'($urandom_range(0, 15)); while (c == CHARS_W'(len));
		return c;
	endfunction

	// A stray item: wrong-length append or the unused action code.
	task automatic send_noise(input int len);
		if ($urandom_range(1)) begin
			send_item(ACT_APPEND, other_length(len), {$urandom(), $urandom()});
		end else begin
			send_item(ACT_UNUSED, CHARS_W'($urandom()), {$urandom(), $urandom()});
		end
	endtask

	// Lookup of a stored word, a near miss or a random word.
	task automatic send_probe(input int len, const ref logic [WORD_W-1:0] words [$],
			input int upto);
		int                pick;
		logic [WORD_W-1:0] probe;
		pick = $urandom_range(99);
		if (upto > 0 && pick < 55) begin
			probe = words[$urandom_range(0, upto - 1)];
		end else if (upto > 0 && pick < 75) begin
			probe = words[$urandom_range(0, upto - 1)] +
				($urandom_range(1) ? 64'd1 : {WORD_W{1'b1}});
		end else begin
			probe = make_word(len);
		end
		// Word length is ignored on lookup, so it is sometimes scrambled.
		send_item(ACT_LOOKUP, $urandom_range(3) == 0 ? CHARS_W'($urandom()) : CHARS_W'(len),
			probe);
	endtask

	// One pass: usually a clear, ascending appends with probes mixed in, then lookups; stray items go into both.
	task automatic run_session(input int len, input int n_words, input int n_lookups,
			input bit to_full);
		logic [WORD_W-1:0] words [$];
		int                pick;
		if ($urandom_range(99) < 90) begin
			send_item(ACT_CLEAR, CHARS_W'($urandom()), {$urandom(), $urandom()});
		end
		for (int i = 0; i < n_words; i++) begin
			words.insert(words.size(), make_word(len));
		end
		words.sort();
		for (int i = 0; i < n_words; i++) begin
			send_item(ACT_APPEND, CHARS_W'(len), words[i]);
			pick = $urandom_range(99);
			if (pick < 6) begin
				send_probe(len, words, i + 1);
			end else if (pick < 9) begin
				send_noise(len);
			end
		end
		// Past capacity: appends are refused, a wrong length is still reported as such.
		if (to_full) begin
			send_item(ACT_APPEND, CHARS_W'(len), make_word(len));
			send_item(ACT_APPEND, other_length(len), make_word(len));
			send_item(ACT_APPEND, CHARS_W'(len), {WORD_W{1'b1}});
			fill_count++;
		end
		for (int i = 0; i < n_lookups; i++) begin
			if ($urandom_range(99) < 10) begin
				send_noise(len);
			end else begin
				send_probe(len, words, n_words);
			end
		end
	endtask

	// Hand-picked items at the reset word length of five characters.
	task automatic run_directed();
		logic [WORD_W-1:0] abcde;
		logic [WORD_W-1:0] abcdf;
		logic [WORD_W-1:0] top5;
		abcde = 64'h4142_4344_4500_0000;
		abcdf = 64'h4142_4344_4600_0000;
		top5  = 64'hFFFF_FFFF_FF00_0000;
		send_item(ACT_LOOKUP, 4'd5, '0);
		send_item(ACT_APPEND, 4'd4, abcde);
		send_item(ACT_APPEND, 4'd5, '0);
		send_item(ACT_APPEND, 4'd5, abcde);
		send_item(ACT_APPEND, 4'd5, abcde);
		send_item(ACT_APPEND, 4'd5, abcdf);
		send_item(ACT_APPEND, 4'd5, top5);
		send_item(ACT_APPEND, 4'd8, {WORD_W{1'b1}});
		send_item(ACT_LOOKUP, 4'd5, '0);
		send_item(ACT_LOOKUP, 4'd15, abcde);
		send_item(ACT_LOOKUP, 4'd0, abcdf);
		send_item(ACT_LOOKUP, 4'd5, top5);
		send_item(ACT_LOOKUP, 4'd8, {WORD_W{1'b1}});
		send_item(ACT_LOOKUP, 4'd5, abcde + 1'b1);
		send_item(ACT_UNUSED, 4'd15, {WORD_W{1'b1}});
		send_item(ACT_CLEAR, 4'd0, '0);
		send_item(ACT_LOOKUP, 4'd5, abcde);
		// Entries stored out of order.
		send_item(ACT_APPEND, 4'd5, abcdf);
		send_item(ACT_APPEND, 4'd5, abcde);
		send_item(ACT_APPEND, 4'd5, '0);
		send_item(ACT_LOOKUP, 4'd5, abcde);
		send_item(ACT_LOOKUP, 4'd5, '0);
		send_item(ACT_LOOKUP, 4'd5, abcdf);
		send_item(ACT_CLEAR, 4'd15, {WORD_W{1'b1}});
	endtask

	// Reset, directed items, then random passes at several word lengths.
	initial begin
		int directed_total;
		int len;
		int session;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req.valid      = 1'b0;
		req.action     = ACT_CLEAR;
		req.word_chars = '0;
		req.word_bits  = '0;
		gaps_on        = 1'b1;
		item_total     = 0;
		setting_count  = 0;
		fill_count     = 0;
		kind_count     = '{default: 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		directed_total = item_total;

		session = 0;
		while (item_total - directed_total < RANDOM_ITEMS) begin
			settle();
			case (session)
				0:       len = MAX_CHARS;
				1:       len = 1;
				default: len = $urandom_range(1, MAX_CHARS);
			endcase
			write_length(len);
			// The pass that fills the table runs with no idling on either side.
			gaps_on = (session != 2);
			if (session == 2) begin
				run_session(len, TABLE_DEPTH, 40, 1'b1);
			end else begin
				run_session(len, $urandom_range(0, 24), $urandom_range(4, 20), 1'b0);
			end
			session++;
		end

		settle();
		repeat (20) @(posedge clk);
		$display("Ran %0d items: %0d clears, %0d appends, %0d lookups, %0d unused codes.",
			item_total, kind_count[ACT_CLEAR], kind_count[ACT_APPEND],
			kind_count[ACT_LOOKUP], kind_count[ACT_UNUSED]);
		$display("Word length was rewritten %0d times; the table ran full %0d time(s).",
			setting_count, fill_count);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/swtl_pkg.sv
rtl/swtl_if.sv
rtl/swtl_ram.sv
rtl/sorted_word_table_lookup_top.sv
rtl/swtl_chk.sv
verif/swtl_result_check.sv
verif/sorted_word_table_lookup_top_tb.sv
